// ----- src/lat1_pkg.sv -----
// Shared types, constants and lookup tables for the Latin-1 charset prober.
`default_nettype none

package lat1_pkg;

	// Counter width and derived widths
	localparam int COUNT_WIDTH = 32;
	localparam int TOTAL_W     = COUNT_WIDTH + 2;   // sum of three counters
	localparam int MAG_W       = COUNT_WIDTH + 5;   // |very - 20 * unlikely|
	localparam int OUT_COUNT_W = 32;                // reported counter width

	// Confidence format: signed Q.16, quotient magnitude below 2^21
	localparam int FRAC_BITS  = 16;
	localparam int Q_BITS     = 21;
	localparam int PRE_SHIFT  = Q_BITS - FRAC_BITS;
	localparam int CONF_W     = 22;
	localparam int STEP_W     = $clog2(Q_BITS);
	localparam logic [CONF_W-1:0] CONF_FLAGGED = CONF_W'(655);

	// Result channel packing
	localparam int OUT_BITS  = 1 + 3 * OUT_COUNT_W + CONF_W;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
	localparam int OUT_TDATA_W = OUT_BYTES * 8;

	// Snapshot queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Character classes
	typedef enum logic [2:0] {
		CLS_NDEF = 3'd0,
		CLS_OTHR = 3'd1,
		CLS_UPPR = 3'd2,
		CLS_LOWR = 3'd3,
		CLS_UPAV = 3'd4,
		CLS_UPAO = 3'd5,
		CLS_LOAV = 3'd6,
		CLS_LOAO = 3'd7
	} class_t;

	// Pair likelihoods
	typedef enum logic [1:0] {
		RATE_ILLEGAL  = 2'd0,
		RATE_UNLIKELY = 2'd1,
		RATE_NEUTRAL  = 2'd2,
		RATE_LIKELY   = 2'd3
	} rating_t;

	// State frozen at a buffer end, handed to the back end
	typedef struct packed {
		logic                   not_latin1;
		logic [COUNT_WIDTH-1:0] very_likely;
		logic [COUNT_WIDTH-1:0] neutral;
		logic [COUNT_WIDTH-1:0] unlikely;
	} tally_t;

	// Row: previous class, column: this class
	localparam logic [1:0] PAIR_MODEL [64] = '{
		2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
		2'd0, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
		2'd0, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
		2'd0, 2'd3, 2'd3, 2'd3, 2'd1, 2'd1, 2'd3, 2'd3,
		2'd0, 2'd3, 2'd3, 2'd3, 2'd1, 2'd2, 2'd1, 2'd2,
		2'd0, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
		2'd0, 2'd3, 2'd1, 2'd3, 2'd1, 2'd1, 2'd1, 2'd3,
		2'd0, 2'd3, 2'd1, 2'd3, 2'd1, 2'd1, 2'd3, 2'd3
	};

	// Accented letters 0xC0..0xFF: low five bits pick vowel, other or symbol
	function automatic logic [1:0] accent_kind(input logic [4:0] low);
		logic [1:0] kind;
		// 0: vowel, 1: other accented, 2: not a letter
		kind = 2'd0;
		priority if (low == 5'h17)                     kind = 2'd2;
		else if (low == 5'h06 || low == 5'h07)          kind = 2'd1;
		else if (low == 5'h10 || low == 5'h11)          kind = 2'd1;
		else if (low >= 5'h1D)                          kind = 2'd1;
		else                                            kind = 2'd0;
		return kind;
	endfunction

	// Byte to character class
	function automatic class_t byte_class(input logic [7:0] b);
		class_t     cls;
		logic [1:0] kind;
		kind = accent_kind(b[4:0]);
		cls  = CLS_OTHR;
		priority case (b) inside
			[8'h41:8'h5A]: cls = CLS_UPPR;
			[8'h61:8'h7A]: cls = CLS_LOWR;
			8'h81, 8'h8D, 8'h8F, 8'h90, 8'h9D: cls = CLS_NDEF;
			8'h83, 8'h9A, 8'h9C, 8'h9E: cls = CLS_LOAO;
			8'h8A, 8'h8C, 8'h8E, 8'h9F: cls = CLS_UPAO;
			[8'hC0:8'hFF]: begin
				if (kind == 2'd2)
					cls = CLS_OTHR;
				else if (b[5])
					cls = (kind == 2'd1) ? CLS_LOAO : CLS_LOAV;
				else
					cls = (kind == 2'd1) ? CLS_UPAO : CLS_UPAV;
			end
			default: cls = CLS_OTHR;
		endcase
		return cls;
	endfunction

endpackage

`default_nettype wire

// ----- src/latin1_charset_prober.sv -----
// Top level of the Latin-1 charset prober: front end, tally queue, back end.
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: data_byte, tuser: restart, tlast: buffer_end
//  m_*     | out | m_tvalid/m_tready  | tdata: flag, three counts, Q.16 confidence
//
// The front end takes one byte per cycle; class lookup, pair scoring and the counter
// update happen in the same cycle. A buffer end queues a tally snapshot (2 entries)
// for the back end, whose sequencer forms the total and sign, runs the serial divider
// (skipped when the flag is set or no pair was counted) and loads the output register.
// Bytes stall only while the queue is full. Reset clears all tallies and the queue.
`default_nettype none

module latin1_charset_prober import lat1_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic [0:0] s_tuser,   // [0] restart
	input  wire logic s_tlast,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata  // [0] not_latin1, [32:1] very_likely_count,
	                                         // [64:33] neutral_count, [96:65] unlikely_count,
	                                         // [118:97] confidence_q16, [119] zero
);

	logic   push, full, pop, head_valid;
	tally_t push_data, head;

	lat1_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.data_byte  (s_tdata),
		.restart    (s_tuser[0]),
		.buffer_end (s_tlast),
		.push       (push),
		.push_data  (push_data),
		.queue_full (full)
	);

	lat1_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	lat1_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

endmodule

`default_nettype wire

// ----- src/lat1_front.sv -----
// Front end: classifies each byte, scores the class pair and keeps the tallies.
`default_nettype none

module lat1_front import lat1_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic   restart,
	input  wire logic   buffer_end,
	output logic        push,
	output tally_t      push_data,
	input  wire logic   queue_full
);

	logic                   flag_q;
	class_t                 prev_q;
	logic [COUNT_WIDTH-1:0] very_q, neutral_q, unlikely_q;

	logic                   base_flag;
	class_t                 base_prev;
	logic [COUNT_WIDTH-1:0] base_very, base_neutral, base_unlikely;
	class_t                 cls;
	rating_t                rating;
	logic                   accept;
	tally_t                 next;
	class_t                 next_prev;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Restart replaces the held state before the byte is scored
	always_comb begin
		base_flag     = restart ? 1'b0 : flag_q;
		base_prev     = restart ? CLS_OTHR : prev_q;
		base_very     = restart ? '0 : very_q;
		base_neutral  = restart ? '0 : neutral_q;
		base_unlikely = restart ? '0 : unlikely_q;
	end

	// Score the pair and bump the matching saturating counter; an illegal pair sets the flag instead
	always_comb begin
		cls       = byte_class(data_byte);
		rating    = rating_t'(PAIR_MODEL[{base_prev, cls}]);
		next.not_latin1  = base_flag;
		next.very_likely = base_very;
		next.neutral     = base_neutral;
		next.unlikely    = base_unlikely;
		next_prev        = base_prev;
		if (!base_flag) begin
			unique case (rating)
				RATE_ILLEGAL: next.not_latin1 = 1'b1;
				RATE_UNLIKELY: begin
					if (base_unlikely != '1)
						next.unlikely = base_unlikely + 1'b1;
					next_prev = cls;
				end
				RATE_NEUTRAL: begin
					if (base_neutral != '1)
						next.neutral = base_neutral + 1'b1;
					next_prev = cls;
				end
				RATE_LIKELY: begin
					if (base_very != '1)
						next.very_likely = base_very + 1'b1;
					next_prev = cls;
				end
				default: next_prev = base_prev;
			endcase
		end
	end

	assign push      = accept && buffer_end;
	assign push_data = next;

	// Tally registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q     <= 1'b0;
			prev_q     <= CLS_OTHR;
			very_q     <= '0;
			neutral_q  <= '0;
			unlikely_q <= '0;
		end else if (accept) begin
			flag_q     <= next.not_latin1;
			prev_q     <= next_prev;
			very_q     <= next.very_likely;
			neutral_q  <= next.neutral;
			unlikely_q <= next.unlikely;
		end
	end

endmodule

`default_nettype wire

// ----- src/lat1_queue.sv -----
// Short FIFO of buffer-end tallies between the front and back ends.
`default_nettype none

module lat1_queue import lat1_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire tally_t push_data,
	output logic        full,
	input  wire logic   pop,
	output logic        head_valid,
	output tally_t      head
);

	tally_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push, do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- src/lat1_back.sv -----
// Back end: computes the Q.16 confidence with a bit-serial divider and holds the result.
`default_nettype none

module lat1_back import lat1_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   head_valid,
	input  wire tally_t head,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOTAL,
		ST_SIGN,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t               state_q;
	tally_t               tally_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [MAG_W-1:0]     ul20_q;
	logic                 neg_q;
	logic [TOTAL_W-1:0]   rem_q;
	logic [Q_BITS-1:0]    dvd_q;
	logic [Q_BITS-1:0]    quot_q;
	logic [STEP_W-1:0]    step_q;
	logic [CONF_W-1:0]    conf_q;
	logic                 out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [TOTAL_W-1:0]   sum;
	logic [MAG_W-1:0]     ul20;
	logic [MAG_W-1:0]     very_ext;
	logic                 neg;
	logic [MAG_W-1:0]     mag;
	logic [TOTAL_W:0]     trial;
	logic [TOTAL_W:0]     diff;
	logic                 qbit;
	logic [TOTAL_W-1:0]   rem_next;
	logic [CONF_W-1:0]    conf_final;
	logic                 out_free;

	assign pop       = (state_q == ST_IDLE) && head_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || out_ready;

	// Total and 20 * unlikely
	always_comb begin
		sum  = TOTAL_W'(tally_q.very_likely) + TOTAL_W'(tally_q.neutral)
		     + TOTAL_W'(tally_q.unlikely);
		ul20 = (MAG_W'(tally_q.unlikely) << 4) + (MAG_W'(tally_q.unlikely) << 2);
	end

	// Sign and magnitude of the numerator
	always_comb begin
		very_ext = MAG_W'(tally_q.very_likely);
		neg      = very_ext < ul20_q;
		mag      = neg ? (ul20_q - very_ext) : (very_ext - ul20_q);
	end

	// One restoring division step
	always_comb begin
		trial    = {rem_q, dvd_q[Q_BITS-1]};
		diff     = trial - {1'b0, total_q};
		qbit     = !diff[TOTAL_W];
		rem_next = qbit ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
	end

	assign conf_final = neg_q ? (CONF_W'(0) - CONF_W'(quot_q)) : CONF_W'(quot_q);

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tally_q     <= '0;
			total_q     <= '0;
			ul20_q      <= '0;
			neg_q       <= 1'b0;
			rem_q       <= '0;
			dvd_q       <= '0;
			quot_q      <= '0;
			step_q      <= '0;
			conf_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// Result valid: set when loaded, cleared when taken
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						tally_q <= head;
						state_q <= ST_TOTAL;
					end
				end
				ST_TOTAL: begin
					total_q <= sum;
					ul20_q  <= ul20;
					if (tally_q.not_latin1) begin
						conf_q  <= CONF_FLAGGED;
						state_q <= ST_DONE;
					end else if (sum == '0) begin
						conf_q  <= '0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					neg_q   <= neg;
					rem_q   <= TOTAL_W'(mag >> PRE_SHIFT);
					dvd_q   <= {mag[PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
					quot_q  <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= rem_next;
					dvd_q  <= {dvd_q[Q_BITS-2:0], 1'b0};
					quot_q <= {quot_q[Q_BITS-2:0], qbit};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(Q_BITS - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_data_q  <= OUT_TDATA_W'({
							((tally_q.not_latin1 || total_q == '0) ? conf_q : conf_final),
							OUT_COUNT_W'(tally_q.unlikely),
							OUT_COUNT_W'(tally_q.neutral),
							OUT_COUNT_W'(tally_q.very_likely),
							tally_q.not_latin1});
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// Conf held in conf_q for the short paths; divider path uses conf_final
			if (state_q == ST_DIV && step_q == STEP_W'(Q_BITS - 1))
				conf_q <= '0;
		end
	end

endmodule

`default_nettype wire
